[hw/rtl/two_marker_pose_estimate_macros.svh]
// assertion macros for the pose estimate block
`ifndef TWO_MARKER_POSE_ESTIMATE_MACROS_SVH
`define TWO_MARKER_POSE_ESTIMATE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define TMPE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define TMPE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `TMPE_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

[hw/rtl/tmpe_pkg.sv]
// package with register codes and constants for the pose estimate block
`timescale 1ns / 1ps

package tmpe_pkg;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH       = 2'd0,
      CSR_IMAGE_HEIGHT      = 2'd1,
      CSR_MARKER_SEPARATION = 2'd2,
      CSR_DEPTH_FACTOR      = 2'd3
   } csr_index_type;

   localparam int CORDIC_STEPS = 15;
   localparam logic [15:0] HALF_PI_Q14 = 16'd25736;

   localparam logic [14:0] ATAN_TAB [CORDIC_STEPS] = '{
      15'd12868, 15'd7596, 15'd4014, 15'd2037, 15'd1023, 15'd512, 15'd256,
      15'd128, 15'd64, 15'd32, 15'd16, 15'd8, 15'd4, 15'd2, 15'd1
   };

   localparam logic [11:0] RESET_WIDTH  = 12'd640;
   localparam logic [11:0] RESET_HEIGHT = 12'd480;

   localparam logic [23:0] POS_MAX   = 24'h7FFFFF;
   localparam logic [23:0] NEG_LIMIT = 24'h800000;
   localparam logic [23:0] Z_MAX     = 24'hFFFFFF;

endpackage

[hw/rtl/two_marker_pose_estimate.sv]
// two-marker pose estimate: fixed point pipeline from marker positions to pose
// throughput: one item per cycle; stages hold on stall and bubbles collapse
// the pipeline length is set by the bit-per-stage square root and the 24 divide stages
// reset clears all stage valid bits and loads the register defaults
// configuration registers are written through the csr channel, always ready
`timescale 1ns / 1ps
`include "two_marker_pose_estimate_macros.svh"

module two_marker_pose_estimate #(
   parameter int COORD_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // first_x, first_y, second_x, second_y
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   // marker_found
   input  logic [0:0]                               req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // pos_x, pos_y, pos_z, roll
   output logic [87:0]                              rsp_tdata,
   // valid_res
   output logic [0:0]                               rsp_tuser,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [1:0]                               csr_index,
   input  logic [23:0]                              csr_wdata
);

   localparam int CB     = COORD_BITS;
   localparam int P      = CB + 5;
   localparam int MW     = (CB + 1 > 16) ? CB + 1 : 16;
   localparam int OW     = MW + 1;
   localparam int W1     = 27 + MW;
   localparam int W2     = P + 28;
   localparam int W12    = (W1 > W2) ? W1 : W2;
   localparam int WW     = ((W12 > 52) ? W12 : 52) + 1;
   localparam int XW     = CB + 19;
   localparam int ZW     = 17;
   localparam int ST_SQ0 = 3;
   localparam int ST_DIV = ST_SQ0 + P;
   localparam int ST_Q0  = ST_DIV + 1;
   localparam int ST_OUT = ST_Q0 + 24;
   localparam int NS     = ST_OUT + 1;

   typedef struct packed {
      logic                 ok;
      logic                 roll_neg;
      logic                 ax_zero;
      logic                 ay_zero;
      logic [CB-1:0]        adx;
      logic [CB-1:0]        ady;
      logic                 offx_pos;
      logic                 offy_pos;
      logic [MW-1:0]        magx;
      logic [MW-1:0]        magy;
      logic [2*CB-1:0]      sqx;
      logic [2*CB-1:0]      sqy;
      logic [35:0]          wsep;
      logic [WW-1:0]        nz;
      logic [WW-1:0]        nx;
      logic [WW-1:0]        ny;
      logic [2*P-1:0]       rad;
      logic [P+1:0]         srem;
      logic [P-1:0]         root;
      logic signed [XW-1:0] cx;
      logic signed [XW-1:0] cy;
      logic signed [ZW-1:0] cz;
      logic                 ovz;
      logic                 ovx;
      logic                 ovy;
      logic [23:0]          qz;
      logic [23:0]          qx;
      logic [23:0]          qy;
      logic                 res_valid;
      logic [23:0]          res_x;
      logic [23:0]          res_y;
      logic [23:0]          res_z;
      logic [15:0]          res_roll;
   } stage_type;

   logic [11:0] width_ff;
   logic [11:0] height_ff;
   logic [23:0] sep_ff;
   logic [15:0] factor_ff;

   stage_type       head;
   stage_type       stage_in [NS];
   stage_type       stage_ff [NS];
   logic [NS-1:0]   vld_ff;
   logic [NS-1:0]   vld_in;
   logic [NS-1:0]   adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tmpe_pkg::RESET_WIDTH;
         height_ff <= tmpe_pkg::RESET_HEIGHT;
         sep_ff    <= '0;
         factor_ff <= '0;
      end else if (csr_valid) begin
         unique case (tmpe_pkg::csr_index_type'(csr_index))
            tmpe_pkg::CSR_IMAGE_WIDTH:       width_ff  <= csr_wdata[11:0];
            tmpe_pkg::CSR_IMAGE_HEIGHT:      height_ff <= csr_wdata[11:0];
            tmpe_pkg::CSR_MARKER_SEPARATION: sep_ff    <= csr_wdata;
            tmpe_pkg::CSR_DEPTH_FACTOR:      factor_ff <= csr_wdata[15:0];
         endcase
      end
   end

   // entry stage: differences, midpoint offsets, special-case flags
   always_comb begin : p_head
      logic [CB-1:0]        fx, fy, sx, sy;
      logic signed [CB:0]   dx, dy;
      logic signed [OW-1:0] offx, offy;
      fx = req_tdata[CB-1:0];
      fy = req_tdata[2*CB-1:CB];
      sx = req_tdata[3*CB-1:2*CB];
      sy = req_tdata[4*CB-1:3*CB];
      dx = $signed({1'b0, fx}) - $signed({1'b0, sx});
      dy = $signed({1'b0, fy}) - $signed({1'b0, sy});
      offx = $signed(OW'({1'b0, fx}) + OW'({1'b0, sx})) - $signed(OW'({width_ff, 4'b0}));
      offy = $signed(OW'({1'b0, fy}) + OW'({1'b0, sy})) - $signed(OW'({height_ff, 4'b0}));
      head = '0;
      head.ax_zero  = (fx == sx);
      head.ay_zero  = (fy == sy);
      head.ok       = req_tuser[0] && !(head.ax_zero && head.ay_zero);
      head.roll_neg = (fy > sy) ? (fx < sx) : (fx > sx);
      head.adx      = dx[CB] ? CB'(-dx) : CB'(dx);
      head.ady      = dy[CB] ? CB'(-dy) : CB'(dy);
      head.offx_pos = (offx > 0);
      head.offy_pos = (offy > 0);
      head.magx     = offx[OW-1] ? MW'(-offx) : MW'(offx);
      head.magy     = offy[OW-1] ? MW'(-offy) : MW'(offy);
   end

   assign adv[NS-1] = !vld_ff[NS-1] || rsp_tready;

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam int CS = (k >= 2 && k < 2 + tmpe_pkg::CORDIC_STEPS) ? k - 2 : 0;
      localparam int QB = (k >= ST_Q0 && k < ST_Q0 + 24) ? ST_Q0 + 23 - k : 0;

      stage_type prev;
      logic      prev_vld;

      if (k == 0) begin : g_first
         assign prev     = head;
         assign prev_vld = req_tvalid;
      end else begin : g_next
         assign prev     = stage_ff[k-1];
         assign prev_vld = vld_ff[k-1];
      end

      if (k < NS - 1) begin : g_adv
         assign adv[k] = !vld_ff[k] || adv[k+1];
      end

      always_comb begin : p_work
         stage_type            s;
         logic [24+MW-1:0]     px, py;
         logic [51:0]          pz;
         logic signed [XW-1:0] xs, ys;
         logic [P+3:0]         t;
         logic [P+3:0]         trial;
         logic [WW-1:0]        dzw, dpw, dzs, dps;
         logic [23:0]          qs, lim;
         logic signed [ZW-1:0] zc;
         logic [15:0]          mag;
         s     = prev;
         px    = '0;
         py    = '0;
         pz    = '0;
         xs    = '0;
         ys    = '0;
         t     = '0;
         trial = '0;
         dzw   = WW'({s.root, 4'b0});
         dpw   = WW'(s.root);
         dzs   = dzw << QB;
         dps   = dpw << QB;
         qs    = '0;
         lim   = '0;
         zc    = '0;
         mag   = '0;
         if (k == 1) begin
            s.sqx  = (2*CB)'(s.adx) * (2*CB)'(s.adx);
            s.sqy  = (2*CB)'(s.ady) * (2*CB)'(s.ady);
            s.wsep = 36'(width_ff) * 36'(sep_ff);
            px     = (24+MW)'(sep_ff) * (24+MW)'(s.magx);
            py     = (24+MW)'(sep_ff) * (24+MW)'(s.magy);
            s.nx   = WW'({px, 3'b0});
            s.ny   = WW'({py, 3'b0});
            s.cx   = $signed(XW'({s.adx, 16'b0}));
            s.cy   = $signed(XW'({s.ady, 16'b0}));
            s.cz   = '0;
         end
         if (k == 2) begin
            s.rad  = (2*P)'({(2*CB+1)'(s.sqx) + (2*CB+1)'(s.sqy), 8'b0});
            pz     = 52'(s.wsep) * 52'(factor_ff);
            s.nz   = WW'(pz);
            s.srem = '0;
            s.root = '0;
            s.qz   = '0;
            s.qx   = '0;
            s.qy   = '0;
         end
         if (k >= 2 && k < 2 + tmpe_pkg::CORDIC_STEPS) begin
            xs = s.cx >>> CS;
            ys = s.cy >>> CS;
            if (s.cy >= 0) begin
               s.cx = s.cx + ys;
               s.cy = s.cy - xs;
               s.cz = s.cz + $signed({2'b00, tmpe_pkg::ATAN_TAB[CS]});
            end else begin
               s.cx = s.cx - ys;
               s.cy = s.cy + xs;
               s.cz = s.cz - $signed({2'b00, tmpe_pkg::ATAN_TAB[CS]});
            end
         end
         if (k >= ST_SQ0 && k < ST_SQ0 + P) begin
            t     = {s.srem, s.rad[2*P-1 -: 2]};
            trial = (P+4)'({s.root, 2'b01});
            if (t >= trial) begin
               s.srem = (P+2)'(t - trial);
               s.root = {s.root[P-2:0], 1'b1};
            end else begin
               s.srem = t[P+1:0];
               s.root = {s.root[P-2:0], 1'b0};
            end
            s.rad = s.rad << 2;
         end
         if (k == ST_DIV) begin
            s.ovz = (s.nz >= (dzw << 24));
            s.ovx = (s.nx >= (dpw << 24));
            s.ovy = (s.ny >= (dpw << 24));
         end
         if (k >= ST_Q0 && k < ST_Q0 + 24) begin
            if (s.nz >= dzs) begin
               s.nz     = s.nz - dzs;
               s.qz[QB] = 1'b1;
            end
            if (s.nx >= dps) begin
               s.nx     = s.nx - dps;
               s.qx[QB] = 1'b1;
            end
            if (s.ny >= dps) begin
               s.ny     = s.ny - dps;
               s.qy[QB] = 1'b1;
            end
         end
         if (k == ST_OUT) begin
            s.res_valid = s.ok;
            s.res_z     = s.ovz ? tmpe_pkg::Z_MAX : s.qz;
            qs = s.ovx ? tmpe_pkg::Z_MAX : s.qx;
            if (s.offx_pos) begin
               lim     = (qs > tmpe_pkg::NEG_LIMIT) ? tmpe_pkg::NEG_LIMIT : qs;
               s.res_x = -lim;
            end else begin
               s.res_x = (qs > tmpe_pkg::POS_MAX) ? tmpe_pkg::POS_MAX : qs;
            end
            qs = s.ovy ? tmpe_pkg::Z_MAX : s.qy;
            if (s.offy_pos) begin
               lim     = (qs > tmpe_pkg::NEG_LIMIT) ? tmpe_pkg::NEG_LIMIT : qs;
               s.res_y = -lim;
            end else begin
               s.res_y = (qs > tmpe_pkg::POS_MAX) ? tmpe_pkg::POS_MAX : qs;
            end
            zc = s.cz;
            if (zc < 0) begin
               mag = '0;
            end else if (zc > $signed({1'b0, tmpe_pkg::HALF_PI_Q14})) begin
               mag = tmpe_pkg::HALF_PI_Q14;
            end else begin
               mag = zc[15:0];
            end
            if (s.ay_zero) begin
               mag = '0;
            end else if (s.ax_zero) begin
               mag = tmpe_pkg::HALF_PI_Q14;
            end
            s.res_roll = s.roll_neg ? -mag : mag;
            if (!s.ok) begin
               s.res_x    = '0;
               s.res_y    = '0;
               s.res_z    = '0;
               s.res_roll = '0;
            end
         end
         stage_in[k] = s;
      end

      assign vld_in[k] = adv[k] ? prev_vld : vld_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign req_tready   = adv[0];
   assign rsp_tvalid   = vld_ff[NS-1];
   assign rsp_tuser[0] = stage_ff[NS-1].res_valid;
   assign rsp_tdata    = {stage_ff[NS-1].res_roll, stage_ff[NS-1].res_z,
                          stage_ff[NS-1].res_y, stage_ff[NS-1].res_x};

   `TMPE_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0, "invalid result carries nonzero pose")
   `TMPE_ASSERT_IMPL(a_roll_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[87:72]) <= 16'sd25736) && ($signed(rsp_tdata[87:72]) >= -16'sd25736), "roll out of range")
   `TMPE_ASSERT_IMPL(a_entry_free, clock, reset, !vld_ff[0], req_tready, "empty entry stage refuses a transfer")

endmodule
